>>> rtl/hmp_pkg.sv
// hmp_pkg: shared types and constants of the hash message padder.
// No dependencies; imported by every module of the block.
package hmp_pkg;

	localparam int WORD_W     = 64;
	localparam int PEND_W     = 56;
	localparam int COUNT_W    = 61;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// word slots inside a 64-byte block
	localparam logic [2:0] SLOT_LAST_PAD = 3'd6;
	localparam logic [2:0] SLOT_LENGTH   = 3'd7;
	localparam logic [2:0] BYTE_LAST     = 3'd7;

	// register index of length_big_endian (paddr[2])
	localparam logic REG_LENGTH_ORDER = 1'b0;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_FIRST,
		EMIT_ZERO,
		EMIT_LENGTH
	} emit_kind_t;

	// controller to datapath
	typedef struct packed {
		logic       take;
		emit_kind_t emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       out_free;
		logic [2:0] first_slot;
		logic [2:0] pad_slot;
	} dp_status_t;

endpackage

>>> rtl/hmp_stream_if.sv
// hmp_stream_if: valid/ready channels for message bytes in and padded words out.
// Depends on nothing.
interface hmp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       carries_byte;
	logic       ends_message;

	modport source (output valid, data_byte, carries_byte, ends_message, input ready);
	modport sink (input valid, data_byte, carries_byte, ends_message, output ready);
endinterface

interface hmp_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_word;
	logic        block_end;
	logic        message_end;

	modport source (output valid, out_word, block_end, message_end, input ready);
	modport sink (input valid, out_word, block_end, message_end, output ready);
endinterface

>>> rtl/hmp_apb_regs.sv
// hmp_apb_regs: APB register file holding the length byte-order control bit.
// Depends on hmp_pkg.
module hmp_apb_regs
	import hmp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic                  length_big_endian
);

	logic lbe_q;
	logic hit;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == REG_LENGTH_ORDER);

	// register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbe_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && hit) begin
			lbe_q <= pwdata[0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(CFG_DATA_W-1){1'b0}}, lbe_q};
		end
	end

	assign length_big_endian = lbe_q;

endmodule

>>> rtl/hmp_datapath.sv
// hmp_datapath: byte packing, length counter, pad word builder, output register.
// Depends on hmp_pkg; driven by hmp_ctrl commands.
module hmp_datapath
	import hmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic        length_big_endian,
	input  logic [7:0]  data_byte,
	input  logic        carries_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_word,
	output logic        block_end,
	output logic        message_end
);

	logic [COUNT_W-1:0] count_q;
	logic [PEND_W-1:0]  pending_q;
	logic [2:0]         pad_slot_q;
	logic               out_valid_q;
	logic [WORD_W-1:0]  word_q;
	logic               block_end_q;
	logic               message_end_q;

	logic               out_free;
	logic [2:0]         byte_pos;
	logic [2:0]         first_slot;
	logic               push;
	logic               word_full;
	logic [WORD_W-1:0]  first_word;
	logic [WORD_W-1:0]  bit_len;
	logic [WORD_W-1:0]  len_word;
	logic [5:0]         first_shift;

	assign out_free   = !out_valid_q || out_ready;
	assign byte_pos   = count_q[2:0];
	assign first_slot = count_q[5:3];
	assign push       = cmd.take && carries_byte;
	assign word_full  = (byte_pos == BYTE_LAST);

	// pending bytes followed by the pad byte, aligned to the top of the word
	assign first_shift = {3'(BYTE_LAST - byte_pos), 3'b000};
	assign first_word  = {pending_q, PAD_BYTE} << first_shift;

	// bit length, byte-swapped for least-significant-first order
	assign bit_len = {count_q, 3'b000};
	always_comb begin
		len_word = bit_len;
		if (!length_big_endian) begin
			len_word = {bit_len[7:0], bit_len[15:8], bit_len[23:16], bit_len[31:24],
				bit_len[39:32], bit_len[47:40], bit_len[55:48], bit_len[63:56]};
		end
	end

	// message byte counter and partial word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pending_q  <= '0;
			pad_slot_q <= '0;
		end else begin
			if (push) begin
				count_q <= count_q + COUNT_W'(1);
				if (word_full) begin
					pending_q <= '0;
				end else begin
					pending_q <= {pending_q[PEND_W-9:0], data_byte};
				end
			end
			unique case (cmd.emit)
				EMIT_FIRST:  pad_slot_q <= first_slot + 3'd1;
				EMIT_ZERO:   pad_slot_q <= pad_slot_q + 3'd1;
				EMIT_LENGTH: begin
					count_q   <= '0;
					pending_q <= '0;
				end
				EMIT_NONE:   ;
				default:     ;
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((push && word_full) || (cmd.emit != EMIT_NONE)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (push && word_full) begin
			word_q        <= {pending_q, data_byte};
			block_end_q   <= (count_q[5:0] == 6'h3f);
			message_end_q <= 1'b0;
		end else begin
			unique case (cmd.emit)
				EMIT_FIRST: begin
					word_q        <= first_word;
					block_end_q   <= (first_slot == SLOT_LENGTH);
					message_end_q <= 1'b0;
				end
				EMIT_ZERO: begin
					word_q        <= '0;
					block_end_q   <= (pad_slot_q == SLOT_LENGTH);
					message_end_q <= 1'b0;
				end
				EMIT_LENGTH: begin
					word_q        <= len_word;
					block_end_q   <= 1'b1;
					message_end_q <= 1'b1;
				end
				EMIT_NONE: ;
				default:   ;
			endcase
		end
	end

	assign status.out_free   = out_free;
	assign status.first_slot = first_slot;
	assign status.pad_slot   = pad_slot_q;

	assign out_valid   = out_valid_q;
	assign out_word    = word_q;
	assign block_end   = block_end_q;
	assign message_end = message_end_q;

endmodule

>>> rtl/hmp_ctrl.sv
// hmp_ctrl: sequencer for message bytes and the padding tail.
// Depends on hmp_pkg; commands hmp_datapath.
module hmp_ctrl
	import hmp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       ends_message,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD_FIRST,
		ST_PAD_ZERO,
		ST_PAD_LEN
	} state_t;

	state_t state_q;

	// commands decoded from state
	always_comb begin
		in_ready = 1'b0;
		cmd.take = 1'b0;
		cmd.emit = EMIT_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = status.out_free;
				cmd.take = in_valid && status.out_free;
			end
			ST_PAD_FIRST: if (status.out_free) cmd.emit = EMIT_FIRST;
			ST_PAD_ZERO:  if (status.out_free) cmd.emit = EMIT_ZERO;
			ST_PAD_LEN:   if (status.out_free) cmd.emit = EMIT_LENGTH;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take && ends_message) state_q <= ST_PAD_FIRST;
				end
				ST_PAD_FIRST: begin
					if (status.out_free) begin
						state_q <= (status.first_slot == SLOT_LAST_PAD) ? ST_PAD_LEN
							: ST_PAD_ZERO;
					end
				end
				ST_PAD_ZERO: begin
					if (status.out_free && status.pad_slot == SLOT_LAST_PAD) begin
						state_q <= ST_PAD_LEN;
					end
				end
				ST_PAD_LEN: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/hash_message_padder.sv
// Merkle-Damgard message padder (MD5 / SHA-256 style). Message bytes come in
// one request per cycle while the output register is free, and leave packed
// as 64-bit words, earliest byte in bits 63:56. A request with ends_message
// set starts the padding tail: the 0x80 byte, zero words up to the last
// slot of a 64-byte block (an extra block when fewer than 9 bytes remain),
// then the 64-bit bit length, least significant byte first unless
// length_big_endian (register at address 0) is set. The tail has 2 to 9
// padding words, which the pad sequencer emits one word per cycle, while
// the output is free, through the single output register. Input is held
// off while the tail drains. No clearing pass after reset.
// Depends on hmp_pkg, hmp_stream_if, hmp_apb_regs, hmp_ctrl, hmp_datapath.
module hash_message_padder
	import hmp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	hmp_in_if.sink                msg_in,
	hmp_out_if.source             word_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic       length_big_endian;
	logic       in_ready;
	dp_cmd_t    cmd;
	dp_status_t status;

	hmp_apb_regs u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.length_big_endian (length_big_endian)
	);

	hmp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (msg_in.valid),
		.ends_message (msg_in.ends_message),
		.in_ready     (in_ready),
		.status       (status),
		.cmd          (cmd)
	);

	hmp_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.length_big_endian (length_big_endian),
		.data_byte         (msg_in.data_byte),
		.carries_byte      (msg_in.carries_byte),
		.out_valid         (word_out.valid),
		.out_ready         (word_out.ready),
		.out_word          (word_out.out_word),
		.block_end         (word_out.block_end),
		.message_end       (word_out.message_end)
	);

	assign msg_in.ready = in_ready;

endmodule

>>> bench/hash_message_padder_test.sv
// hash_message_padder_test: self-checking bench for the message padder, with
// random idling on both stream sides and APB writes of the length byte order.
// Depends on hmp_pkg, hmp_stream_if and the hash_message_padder RTL.
`timescale 1ns / 100ps

module hash_message_padder_test;
	import hmp_pkg::*;

	localparam logic [CFG_ADDR_W-1:0] ADDR_LENGTH_ORDER = {REG_LENGTH_ORDER, 2'b00};
	localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED       = {~REG_LENGTH_ORDER, 2'b00};
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [7:0] data_byte;
		logic       carries_byte;
		logic       ends_message;
		logic       hold;          // sender waits for all words before this request
	} msg_request_t;

	typedef struct {
		logic [63:0] out_word;
		logic        block_end;
		logic        message_end;
	} padded_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, known from time zero
	logic                  in_valid = 1'b0;
	logic [7:0]            in_data = '0;
	logic                  in_carries = 1'b0;
	logic                  in_ends = 1'b0;
	logic                  sink_ready = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	hmp_in_if  msg_in();
	hmp_out_if word_out();

	assign msg_in.valid        = in_valid;
	assign msg_in.data_byte    = in_data;
	assign msg_in.carries_byte = in_carries;
	assign msg_in.ends_message = in_ends;
	assign word_out.ready      = sink_ready;

	hash_message_padder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_in   (msg_in),
		.word_out (word_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	// stimulus and prediction state
	msg_request_t pending_requests[$];
	padded_word_t padded_words_q[$];
	int unsigned  words_outstanding = 0;
	logic         burst = 1'b0;
	logic         len_big_endian = 1'b0;
	logic [60:0]  msg_bytes = '0;
	logic [55:0]  open_word = '0;
	int unsigned  src_wait = 0;
	int unsigned  sink_wait = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  fail_count = 0;
	int unsigned  requests_planned = 0;
	int unsigned  requests_seen = 0;
	int unsigned  messages_seen = 0;
	int unsigned  words_checked = 0;
	int unsigned  reg_writes = 0;

	// Append one byte at stream position pos; a full word goes to the expected queue.
	task automatic pack_byte(input logic [7:0] b, inout logic [60:0] pos);
		padded_word_t w;
		if (pos[2:0] == 3'd7) begin
			w.out_word    = {open_word, b};
			w.block_end   = (pos[5:0] == 6'd63);
			w.message_end = 1'b0;
			padded_words_q.push_back(w);
			open_word = '0;
		end else begin
			open_word = {open_word[47:0], b};
		end
		pos = pos + 61'd1;
	endtask

	// Expected words for one accepted request, padding tail included.
	task automatic pad_request(input logic [7:0] b, input logic carries, input logic ends);
		logic [63:0] bit_len;
		logic [60:0] pos;
		if (carries)
			pack_byte(b, msg_bytes);
		if (ends) begin
			bit_len = {msg_bytes, 3'b000};
			pos = msg_bytes;
			pack_byte(PAD_BYTE, pos);
			while (pos[5:0] != 6'd56)
				pack_byte(8'h00, pos);
			for (int i = 0; i < 8; i++)
				pack_byte(len_big_endian ? bit_len[8*(7-i) +: 8] : bit_len[8*i +: 8], pos);
			padded_words_q[padded_words_q.size()-1].message_end = 1'b1;
			msg_bytes = '0;
			open_word = '0;
		end
	endtask

	// Request driver: random gap before each request, optional drain hold-off
	always @(posedge clk or negedge arst_n) begin : request_driver
		msg_request_t nxt;
		logic accepted;
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_wait <= 0;
		end else begin
			accepted = in_valid && msg_in.ready;
			if (!in_valid || accepted) begin
				if (src_wait != 0) begin
					src_wait <= src_wait - 1;
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0 &&
						!(pending_requests[0].hold && (accepted || words_outstanding != 0))) begin
					nxt = pending_requests.pop_front();
					in_valid   <= 1'b1;
					in_data    <= nxt.data_byte;
					in_carries <= nxt.carries_byte;
					in_ends    <= nxt.ends_message;
					src_wait   <= burst ? 0 : $urandom_range(0, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Word sink: random stall after each accepted word
	always @(posedge clk or negedge arst_n) begin : word_sink
		int unsigned stall;
		if (!arst_n) begin
			sink_ready <= 1'b0;
			sink_wait <= 0;
		end else if (word_out.valid && sink_ready) begin
			stall = burst ? 0 : $urandom_range(0, 11);
			sink_wait <= stall;
			sink_ready <= (stall == 0);
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			sink_ready <= (sink_wait == 1);
		end else begin
			sink_ready <= 1'b1;
		end
	end

	// Predict on accepted requests, compare accepted words against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : padding_checker
		padded_word_t exp_w;
		if (!arst_n) begin
			msg_bytes = '0;
			open_word = '0;
			words_outstanding <= 0;
		end else begin
			if (in_valid && msg_in.ready) begin
				pad_request(in_data, in_carries, in_ends);
				requests_seen++;
				if (in_ends)
					messages_seen++;
			end
			if (word_out.valid && sink_ready) begin
				if (padded_words_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected word %h block_end %b message_end %b",
							word_out.out_word, word_out.block_end, word_out.message_end);
				end else begin
					exp_w = padded_words_q.pop_front();
					words_checked++;
					if (word_out.out_word !== exp_w.out_word ||
							word_out.block_end !== exp_w.block_end ||
							word_out.message_end !== exp_w.message_end) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("word mismatch: expected %h/%b/%b got %h/%b/%b",
								exp_w.out_word, exp_w.block_end, exp_w.message_end,
								word_out.out_word, word_out.block_end, word_out.message_end);
					end
				end
			end
			words_outstanding <= padded_words_q.size();
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && msg_in.ready) || (word_out.valid && sink_ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("hash_message_padder test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_LENGTH_ORDER)
			len_big_endian = data[0];
		reg_writes++;
		@(negedge clk);
	endtask

	// Read back the byte order register, sampled mid access phase
	task automatic check_length_order;
		logic [CFG_DATA_W-1:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_LENGTH_ORDER;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== {{(CFG_DATA_W-1){1'b0}}, len_big_endian}) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("register read mismatch: expected %h got %h",
					{{(CFG_DATA_W-1){1'b0}}, len_big_endian}, got);
		end
		@(negedge clk);
	endtask

	task automatic queue_request(input logic [7:0] b, input logic carries, input logic ends,
			input logic hold);
		msg_request_t r;
		r.data_byte    = b;
		r.carries_byte = carries;
		r.ends_message = ends;
		r.hold         = hold;
		pending_requests.push_back(r);
		if (carries || ends)
			requests_planned++;
	endtask

	// One message of random bytes, with stray no-byte requests mixed in
	task automatic queue_message(input int len, input logic end_with_byte, input logic hold);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				queue_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
			queue_request(8'($urandom_range(0, 255)), 1'b1, end_with_byte && i == len - 1,
				hold && i == 0);
		end
		if (len == 0 || !end_with_byte)
			queue_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, hold && len == 0);
	endtask

	// Random messages, lengths trimmed to what is left of the budget
	task automatic queue_random_messages(input int budget);
		int unsigned target;
		int unsigned pick;
		int len;
		int remaining;
		target = requests_planned + budget;
		while (requests_planned < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				len = $urandom_range(0, 20);
			else if (pick < 85)
				case ($urandom_range(0, 5))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					default: len = 65;
				endcase
			else
				len = $urandom_range(21, 130);
			remaining = int'(target - requests_planned);
			if (len > remaining)
				len = remaining;
			queue_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
		end
	endtask

	// Wait until every word has come back, then let the tail logic settle
	task automatic drain_and_pause;
		while (pending_requests.size() != 0 || in_valid || padded_words_q.size() != 0)
			@(negedge clk);
		repeat (20)
			@(negedge clk);
	endtask

	initial begin : stimulus
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset byte order (little endian), edge cases of the fields
		queue_request(8'hFF, 1'b0, 1'b1, 1'b0);       // empty message, data ignored
		queue_request(8'h00, 1'b0, 1'b0, 1'b0);       // stray request, no byte
		queue_request(8'hFF, 1'b1, 1'b1, 1'b0);       // one byte, ends with it
		queue_request(8'h61, 1'b1, 1'b0, 1'b0);
		queue_request(8'h62, 1'b1, 1'b0, 1'b0);
		queue_request(8'h63, 1'b1, 1'b0, 1'b0);
		queue_request(8'h00, 1'b0, 1'b1, 1'b1);       // end without byte, after a drain
		for (int i = 0; i < 7; i++)
			queue_request(8'hFF, 1'b1, 1'b0, 1'b0);
		queue_request(8'h00, 1'b1, 1'b1, 1'b0);       // full word then padding
		for (int i = 0; i < 8; i++)
			queue_request(8'h80 >> i, 1'b1, 1'b0, 1'b0);
		queue_request(8'h55, 1'b0, 1'b1, 1'b0);
		queue_request(8'hAA, 1'b0, 1'b1, 1'b1);       // second empty message, after a drain
		drain_and_pause();
		check_length_order();

		// big endian length
		apb_write(ADDR_LENGTH_ORDER, 32'd1);
		check_length_order();
		queue_message(56, 1'b1, 1'b0);
		queue_random_messages(10);
		drain_and_pause();

		// back to little endian; a write to the unused index must not matter
		apb_write(ADDR_LENGTH_ORDER, 32'd0);
		apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
		check_length_order();
		burst = 1'b1;
		queue_message(55, 1'b0, 1'b0);
		queue_random_messages(10);
		drain_and_pause();
		burst = 1'b0;

		// all-ones and all-but-bit-0 write data
		apb_write(ADDR_LENGTH_ORDER, 32'hFFFF_FFFF);
		check_length_order();
		queue_random_messages(5);
		drain_and_pause();
		apb_write(ADDR_LENGTH_ORDER, 32'hFFFF_FFFE);
		check_length_order();
		queue_random_messages(5);
		drain_and_pause();

		fail_count += padded_words_q.size();
		$display("%0d requests in %0d messages gave %0d padded words; %0d register writes",
			requests_seen, messages_seen, words_checked, reg_writes);
		$display("both length byte orders, block boundary lengths and empty messages covered");
		if (fail_count == 0)
			$display("hash_message_padder test passed");
		else
			$display("hash_message_padder test failed");
		$finish;
	end

endmodule
